// ===== rtl/tlc_pkg.sv =====
// Shared types and constants for the touch linear calibration block.
// Used by tlc_divider and touch_linear_calibration; depends on nothing.
`default_nettype none

package tlc_pkg;

   // Widths of the fixed result fields.
   localparam int SCALE_BITS = 26;
   localparam int COEF_BITS  = 32;

   // Scale numerators: pixel span times 65536 (280 for x, 200 for y).
   localparam int NUM_BITS = 25;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   localparam logic [NUM_BITS-1:0] X_SCALE_NUM = NUM_BITS'(280 * 65536);
   localparam logic [NUM_BITS-1:0] Y_SCALE_NUM = NUM_BITS'(200 * 65536);

   // Q16 position of the first calibration target (pixel 20).
   localparam logic [COEF_BITS-1:0] OFFSET_BASE = COEF_BITS'(20 * 65536);

   // Debounce window after reset, in milliseconds.
   localparam logic [15:0] DEBOUNCE_RESET = 16'd300;

   // Command codes.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_TOUCH  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   // Phase codes.
   localparam logic [2:0] PHASE_IDLE  = 3'd0;
   localparam logic [2:0] PHASE_FIRST = 3'd1;
   localparam logic [2:0] PHASE_LAST  = 3'd4;
   localparam logic [2:0] PHASE_DONE  = 3'd5;

   // Sequencer states.
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PREP = 6'b000010,
      S_DIV  = 6'b000100,
      S_MUL  = 6'b001000,
      S_OFS  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/tlc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tlc_pkg for the numerator width and the status type.
`default_nettype none

module tlc_divider
   import tlc_pkg::*;
#(
   parameter int DIVISOR_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_BITS-1:0]     dividend,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output logic [NUM_BITS-1:0]     quotient,
   output div_status_type          status
);

   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0]     quo_ff, quo_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    done_ff, done_in;

   logic [DIVISOR_BITS:0]   partial;
   logic [DIVISOR_BITS:0]   diff;
   logic                    fits;

   // Trial subtraction of the divisor from the shifted remainder.
   assign partial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign diff    = partial - {1'b0, divisor};
   assign fits    = partial >= {1'b0, divisor};

   // Next state of the iteration.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_BITS'(NUM_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : partial[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[NUM_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   // Control registers take reset; the datapath does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/touch_linear_calibration.sv =====
// Four-point touch calibration sequencer with Q16 scale and offset output.
// Depends on tlc_pkg and instantiates tlc_divider.
//
// Usage: items arrive on the req_ channel (valid/ready) with a command, the
// millisecond tick and raw x/y readings. Each item gives exactly one result on
// the rsp_ channel (valid/ready) carrying the touch and completion flags, the
// phase and the current coefficients. csr_wr_en writes the debounce window
// at once; write it only while the block is idle.
// An item that does not finish a calibration goes straight to the output
// register, so its result can be taken in the cycle after it is accepted.
// The item that takes the fourth point runs the shared divider for x and then
// for y (25 quotient steps each), with a multiply and an offset step per axis
// (states S_PREP, then S_DIV, S_MUL and S_OFS per axis, then S_OUT) before its
// result is registered; when a span is zero the divider is skipped (S_PREP to S_OUT).
// One item is in work at a time; req_ready is high only while the sequencer
// is idle and the output register is empty or being emptied.
// Reset: phase idle, timestamp zero, coefficients zero, valid flag clear,
// debounce 300 ms, no result pending.
// When the receiver stalls, the result holds in the output register and no
// new item is taken until it is delivered.
`default_nettype none

module touch_linear_calibration
   import tlc_pkg::*;
#(
   parameter int RAW_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration
   input  logic                         csr_wr_en,
   input  logic [15:0]                  csr_wr_data,
   // Input items
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [31:0]                  req_now_ms,
   input  logic [RAW_BITS-1:0]          req_raw_x,
   input  logic [RAW_BITS-1:0]          req_raw_y,
   // Result items
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_touch_taken,
   output logic                         rsp_calib_done,
   output logic                         rsp_calib_valid,
   output logic [2:0]                   rsp_phase,
   output logic signed [SCALE_BITS-1:0] rsp_x_scale,
   output logic signed [COEF_BITS-1:0]  rsp_x_offset,
   output logic signed [SCALE_BITS-1:0] rsp_y_scale,
   output logic signed [COEF_BITS-1:0]  rsp_y_offset
);

   localparam int MUL_BITS = SCALE_BITS + RAW_BITS + 1;

   // Control state
   state_type                    state_ff, state_in;
   logic                         axis_ff, axis_in;
   logic [2:0]                   phase_ff, phase_in;
   logic [31:0]                  last_ms_ff, last_ms_in;
   logic [15:0]                  debounce_ff, debounce_in;
   logic                         valid_ff, valid_in;
   logic                         div_start_ff, div_start_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_taken_ff, rsp_taken_in;
   logic                         rsp_done_ff, rsp_done_in;

   // Datapath state
   logic [RAW_BITS-1:0]          sample_x_ff [4];
   logic [RAW_BITS-1:0]          sample_x_in [4];
   logic [RAW_BITS-1:0]          sample_y_ff [4];
   logic [RAW_BITS-1:0]          sample_y_in [4];
   logic [RAW_BITS-1:0]          avg_x_ff, avg_x_in;
   logic [RAW_BITS-1:0]          avg_y_ff, avg_y_in;
   logic signed [RAW_BITS:0]     span_x_ff, span_x_in;
   logic signed [RAW_BITS:0]     span_y_ff, span_y_in;
   logic signed [SCALE_BITS-1:0] x_scale_ff, x_scale_in;
   logic signed [SCALE_BITS-1:0] y_scale_ff, y_scale_in;
   logic signed [COEF_BITS-1:0]  x_offset_ff, x_offset_in;
   logic signed [COEF_BITS-1:0]  y_offset_ff, y_offset_in;
   logic [COEF_BITS-1:0]         prod_ff, prod_in;

   // Combinational helpers
   logic                         accept;
   logic [31:0]                  elapsed;
   logic                         debounce_ok;
   logic [1:0]                   slot;
   logic [RAW_BITS:0]            sum_x20, sum_x300, sum_y20, sum_y220;
   logic [RAW_BITS-1:0]          avg_x300, avg_y220;
   logic signed [RAW_BITS:0]     span_cur, span_abs;
   logic                         span_neg;
   logic [NUM_BITS-1:0]          div_dividend;
   logic [NUM_BITS-1:0]          div_quotient;
   div_status_type               div_status;
   logic signed [SCALE_BITS-1:0] scale_mag, scale_new, scale_cur;
   logic [RAW_BITS-1:0]          avg_cur;
   logic signed [MUL_BITS-1:0]   mul_full;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);

   // Debounce test with 32-bit wrap.
   assign elapsed     = req_now_ms - last_ms_ff;
   assign debounce_ok = elapsed >= {16'd0, debounce_ff};
   assign slot        = 2'(phase_ff - PHASE_FIRST);

   // Pair averages: x at 20 from points 1 and 3, at 300 from 2 and 4;
   // y at 20 from points 1 and 2, at 220 from 3 and 4.
   assign sum_x20  = {1'b0, sample_x_ff[0]} + {1'b0, sample_x_ff[2]};
   assign sum_x300 = {1'b0, sample_x_ff[1]} + {1'b0, sample_x_ff[3]};
   assign sum_y20  = {1'b0, sample_y_ff[0]} + {1'b0, sample_y_ff[1]};
   assign sum_y220 = {1'b0, sample_y_ff[2]} + {1'b0, sample_y_ff[3]};
   assign avg_x300 = sum_x300[RAW_BITS:1];
   assign avg_y220 = sum_y220[RAW_BITS:1];

   // Divider operands for the axis in work: magnitudes, sign fixed after.
   assign span_cur     = axis_ff ? span_y_ff : span_x_ff;
   assign span_neg     = span_cur[RAW_BITS];
   assign span_abs     = span_neg ? -span_cur : span_cur;
   assign div_dividend = axis_ff ? Y_SCALE_NUM : X_SCALE_NUM;

   tlc_divider #(
      .DIVISOR_BITS (RAW_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (span_abs[RAW_BITS-1:0]),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Truncated signed quotient and the scale-times-average product.
   assign scale_mag = $signed({1'b0, div_quotient});
   assign scale_new = span_neg ? -scale_mag : scale_mag;
   assign scale_cur = axis_ff ? y_scale_ff : x_scale_ff;
   assign avg_cur   = axis_ff ? avg_y_ff : avg_x_ff;
   assign mul_full  = MUL_BITS'(scale_cur) * MUL_BITS'($signed({1'b0, avg_cur}));

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      phase_in     = phase_ff;
      last_ms_in   = last_ms_ff;
      debounce_in  = csr_wr_en ? csr_wr_data : debounce_ff;
      valid_in     = valid_ff;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_taken_in = rsp_taken_ff;
      rsp_done_in  = rsp_done_ff;
      sample_x_in  = sample_x_ff;
      sample_y_in  = sample_y_ff;
      avg_x_in     = avg_x_ff;
      avg_y_in     = avg_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      x_scale_in   = x_scale_ff;
      y_scale_in   = y_scale_ff;
      x_offset_in  = x_offset_ff;
      y_offset_in  = y_offset_ff;
      prod_in      = prod_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_taken_in = 1'b0;
               rsp_done_in  = 1'b0;
               case (req_opcode)
                  OP_START: begin
                     phase_in   = PHASE_FIRST;
                     last_ms_in = req_now_ms;
                  end
                  OP_CANCEL: begin
                     phase_in = PHASE_IDLE;
                  end
                  OP_TOUCH: begin
                     if (debounce_ok) begin
                        last_ms_in   = req_now_ms;
                        rsp_taken_in = 1'b1;
                        if (phase_ff >= PHASE_FIRST && phase_ff <= PHASE_LAST) begin
                           sample_x_in[slot] = req_raw_x;
                           sample_y_in[slot] = req_raw_y;
                           if (phase_ff == PHASE_LAST) begin
                              // Fourth point: result waits for the coefficients.
                              phase_in     = PHASE_DONE;
                              rsp_valid_in = 1'b0;
                              state_in     = S_PREP;
                           end else begin
                              phase_in = phase_ff + 3'd1;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PREP: begin
            avg_x_in  = sum_x20[RAW_BITS:1];
            avg_y_in  = sum_y20[RAW_BITS:1];
            span_x_in = $signed({1'b0, avg_x300}) - $signed({1'b0, sum_x20[RAW_BITS:1]});
            span_y_in = $signed({1'b0, avg_y220}) - $signed({1'b0, sum_y20[RAW_BITS:1]});
            if (span_x_in == '0 || span_y_in == '0) begin
               // A degenerate span keeps the old coefficients.
               valid_in = 1'b0;
               state_in = S_OUT;
            end else begin
               axis_in      = 1'b0;
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               if (axis_ff) begin
                  y_scale_in = scale_new;
               end else begin
                  x_scale_in = scale_new;
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mul_full[COEF_BITS-1:0];
            state_in = S_OFS;
         end
         S_OFS: begin
            if (axis_ff) begin
               y_offset_in = $signed(OFFSET_BASE - prod_ff);
               valid_in    = 1'b1;
               state_in    = S_OUT;
            end else begin
               x_offset_in  = $signed(OFFSET_BASE - prod_ff);
               axis_in      = 1'b1;
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_taken_in = 1'b1;
            rsp_done_in  = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Registers: control and architectural state reset, working values do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         phase_ff     <= PHASE_IDLE;
         last_ms_ff   <= '0;
         debounce_ff  <= DEBOUNCE_RESET;
         valid_ff     <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_scale_ff   <= '0;
         y_scale_ff   <= '0;
         x_offset_ff  <= '0;
         y_offset_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         phase_ff     <= phase_in;
         last_ms_ff   <= last_ms_in;
         debounce_ff  <= debounce_in;
         valid_ff     <= valid_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         x_scale_ff   <= x_scale_in;
         y_scale_ff   <= y_scale_in;
         x_offset_ff  <= x_offset_in;
         y_offset_ff  <= y_offset_in;
      end
      rsp_taken_ff <= rsp_taken_in;
      rsp_done_ff  <= rsp_done_in;
      sample_x_ff  <= sample_x_in;
      sample_y_ff  <= sample_y_in;
      avg_x_ff     <= avg_x_in;
      avg_y_ff     <= avg_y_in;
      span_x_ff    <= span_x_in;
      span_y_ff    <= span_y_in;
      prod_ff      <= prod_in;
   end

   // The coefficients and phase only change while no result is pending.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_touch_taken = rsp_taken_ff;
   assign rsp_calib_done  = rsp_done_ff;
   assign rsp_calib_valid = valid_ff;
   assign rsp_phase       = phase_ff;
   assign rsp_x_scale     = x_scale_ff;
   assign rsp_x_offset    = x_offset_ff;
   assign rsp_y_scale     = y_scale_ff;
   assign rsp_y_offset    = y_offset_ff;

endmodule

`default_nettype wire
